// ----- rtl/graph_label_multiset_filter_macros.svh -----
// assertion helpers used by glmf_back
`ifndef GRAPH_LABEL_MULTISET_FILTER_MACROS_SVH
`define GRAPH_LABEL_MULTISET_FILTER_MACROS_SVH

// property that must hold at every clock edge out of reset
`define GLMF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen out of reset
`define GLMF_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- rtl/glmf_pkg.sv -----
package glmf_pkg;

  // default sizes
  localparam int unsigned MAX_LABELS_DEF = 64;
  localparam int unsigned LABEL_BITS_DEF = 16;
  localparam int unsigned COUNT_BITS_DEF = 12;

  // fixed field widths
  localparam int unsigned TOTAL_BITS = 12;
  localparam int unsigned NUM_TOTALS = 4;
  localparam int unsigned BOUND_BITS = 8;
  localparam logic [BOUND_BITS-1:0] BOUND_RESET = 8'd1;
  localparam int unsigned MODE_BITS = 3;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // store selects
  localparam int unsigned NUM_STORES = 4;
  localparam int unsigned STORE_SEL_BITS = 2;
  localparam logic [STORE_SEL_BITS-1:0] STORE_FIRST_VERTEX  = 2'd0;
  localparam logic [STORE_SEL_BITS-1:0] STORE_SECOND_VERTEX = 2'd1;
  localparam logic [STORE_SEL_BITS-1:0] STORE_FIRST_EDGE    = 2'd2;
  localparam logic [STORE_SEL_BITS-1:0] STORE_SECOND_EDGE   = 2'd3;

  // input item kinds
  typedef enum logic [MODE_BITS-1:0] {
    MODE_LOAD_FV = 3'd0,
    MODE_LOAD_SV = 3'd1,
    MODE_LOAD_FE = 3'd2,
    MODE_LOAD_SE = 3'd3,
    MODE_EVAL    = 3'd4
  } mode_e;

  // classified command
  typedef struct packed {
    logic                      is_eval;
    logic [STORE_SEL_BITS-1:0] store_sel;
  } cmd_t;

  // result, pass in the lowest bit
  typedef struct packed {
    logic                  overflow;
    logic [TOTAL_BITS-1:0] edge_error;
    logic [TOTAL_BITS-1:0] vertex_error;
    logic                  rejected_on_vertices;
    logic                  pass;
  } res_t;

  localparam int unsigned OUT_DATA_BITS = $bits(res_t);
  localparam int unsigned OUT_TDATA_W   = ((OUT_DATA_BITS + 7) / 8) * 8;

  // back-end sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MERGE,
    ST_VCHECK,
    ST_ECHECK,
    ST_RESULT
  } back_state_e;

endpackage

// ----- rtl/graph_label_multiset_filter.sv -----
// channel   | dir | handshake              | payload
// ----------+-----+------------------------+-----------------------------------------
// s_axis    | in  | s_axis_tvalid/tready   | tuser mode, tdata label..second_edge_count
// m_axis    | out | m_axis_tvalid/tready   | tdata pass..overflow
// cfg       | in  | cfg_we_i               | cfg_wdata_i error_bound
//
// a load writes one store word and bumps its fill count, or sets the drop flag if that store is full
// an evaluate merges the vertex stores, then, unless the vertex error is over the bound, the edge stores:
//   the merge walk advances one entry of a store pair per cycle, limited by the
//   registered read port of each store ram
// a two-entry command queue lets loads be taken while an evaluate is at work
// reset clears fill counts, the drop flag and the sequencer; the stores need no clearing
// a waiting result sits in the output register and stalls the back end, and the input once the queue is full
module graph_label_multiset_filter #(
  parameter int unsigned MAX_LABELS = glmf_pkg::MAX_LABELS_DEF,
  parameter int unsigned LABEL_BITS = glmf_pkg::LABEL_BITS_DEF,
  parameter int unsigned COUNT_BITS = glmf_pkg::COUNT_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // label, count, first_vertex_count, second_vertex_count,
  // first_edge_count, second_edge_count
  input  logic [((LABEL_BITS+COUNT_BITS+glmf_pkg::NUM_TOTALS*glmf_pkg::TOTAL_BITS+7)/8)*8-1:0]
               s_axis_tdata,
  // mode
  input  logic [glmf_pkg::MODE_BITS-1:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // pass, rejected_on_vertices, vertex_error, edge_error, overflow
  output logic [glmf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic cfg_we_i,
  input  logic [glmf_pkg::BOUND_BITS-1:0] cfg_wdata_i
);

  localparam int unsigned DATA_BITS =
    LABEL_BITS + COUNT_BITS + glmf_pkg::NUM_TOTALS * glmf_pkg::TOTAL_BITS;
  localparam int unsigned CMD_BITS   = $bits(glmf_pkg::cmd_t);
  localparam int unsigned ENTRY_BITS = DATA_BITS + CMD_BITS;

  logic [glmf_pkg::BOUND_BITS-1:0] bound_q;
  logic                  push, queue_full, queue_valid, pop;
  logic [ENTRY_BITS-1:0] push_entry, head_entry;
  glmf_pkg::res_t        res;

  // error bound register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_q <= glmf_pkg::BOUND_RESET;
    end else if (cfg_we_i) begin
      bound_q <= cfg_wdata_i;
    end
  end

  // accept and classify
  glmf_front #(
    .DATA_BITS (DATA_BITS)
  ) u_front (
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_mode_i    (s_axis_tuser),
    .in_data_i    (s_axis_tdata[DATA_BITS-1:0]),
    .queue_full_i (queue_full),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  // command queue
  glmf_queue #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (glmf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .rdata_o (head_entry)
  );

  // stores, merge and result
  glmf_back #(
    .MAX_LABELS (MAX_LABELS),
    .LABEL_BITS (LABEL_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (queue_valid),
    .cmd_i       (glmf_pkg::cmd_t'(head_entry[CMD_BITS-1:0])),
    .cmd_data_i  (head_entry[ENTRY_BITS-1:CMD_BITS]),
    .cmd_pop_o   (pop),
    .bound_i     (bound_q),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {{(glmf_pkg::OUT_TDATA_W - glmf_pkg::OUT_DATA_BITS){1'b0}}, res};

endmodule

// ----- rtl/glmf_ram.sv -----
module glmf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/glmf_queue.sv -----
module glmf_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = glmf_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue slots
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- rtl/glmf_front.sv -----
module glmf_front #(
  parameter int unsigned DATA_BITS = 8
) (
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [glmf_pkg::MODE_BITS-1:0] in_mode_i,
  input  logic [DATA_BITS-1:0]           in_data_i,
  input  logic                           queue_full_i,
  output logic                           push_o,
  output logic [DATA_BITS+$bits(glmf_pkg::cmd_t)-1:0] entry_o
);

  glmf_pkg::cmd_t cmd;
  logic           keep;

  // classify the item; unused kinds are taken and dropped
  always_comb begin
    cmd.is_eval   = 1'b0;
    cmd.store_sel = glmf_pkg::STORE_FIRST_VERTEX;
    keep          = 1'b1;
    case (glmf_pkg::mode_e'(in_mode_i))
      glmf_pkg::MODE_LOAD_FV: cmd.store_sel = glmf_pkg::STORE_FIRST_VERTEX;
      glmf_pkg::MODE_LOAD_SV: cmd.store_sel = glmf_pkg::STORE_SECOND_VERTEX;
      glmf_pkg::MODE_LOAD_FE: cmd.store_sel = glmf_pkg::STORE_FIRST_EDGE;
      glmf_pkg::MODE_LOAD_SE: cmd.store_sel = glmf_pkg::STORE_SECOND_EDGE;
      glmf_pkg::MODE_EVAL:    cmd.is_eval   = 1'b1;
      default:                keep          = 1'b0;
    endcase
  end

  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i && keep;
  assign entry_o    = {in_data_i, cmd};

endmodule

// ----- rtl/glmf_back.sv -----
`include "graph_label_multiset_filter_macros.svh"

module glmf_back #(
  parameter int unsigned MAX_LABELS = glmf_pkg::MAX_LABELS_DEF,
  parameter int unsigned LABEL_BITS = glmf_pkg::LABEL_BITS_DEF,
  parameter int unsigned COUNT_BITS = glmf_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cmd_valid_i,
  input  glmf_pkg::cmd_t                  cmd_i,
  input  logic [LABEL_BITS+COUNT_BITS+glmf_pkg::NUM_TOTALS*glmf_pkg::TOTAL_BITS-1:0] cmd_data_i,
  output logic                            cmd_pop_o,
  input  logic [glmf_pkg::BOUND_BITS-1:0] bound_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output glmf_pkg::res_t                  res_o
);

  localparam int unsigned TB    = glmf_pkg::TOTAL_BITS;
  localparam int unsigned NS    = glmf_pkg::NUM_STORES;
  localparam int unsigned AW    = $clog2(MAX_LABELS);
  localparam int unsigned IW    = $clog2(MAX_LABELS + 1);
  localparam int unsigned EB    = LABEL_BITS + COUNT_BITS;
  localparam int unsigned OVL_W = COUNT_BITS + IW;
  localparam int unsigned CMP_W = (OVL_W > TB) ? OVL_W : TB;
  localparam int unsigned SUM_W = TB + 1;

  glmf_pkg::back_state_e state_q, state_d;

  logic [IW-1:0]    len_q [NS];
  logic [IW-1:0]    len_d [NS];
  logic             drop_q, drop_d;
  logic [IW-1:0]    s_q, s_d, t_q, t_d;
  logic [OVL_W-1:0] ovl_q, ovl_d;
  logic             edge_phase_q, edge_phase_d;
  logic [TB-1:0]    verr_q, verr_d, eerr_q, eerr_d;
  logic             early_q, early_d, pass_q, pass_d;
  logic [TB-1:0]    fv_q, sv_q, fe_q, se_q;
  logic             res_valid_q, res_valid_d;
  glmf_pkg::res_t   res_q, res_d;

  logic [NS-1:0]    we;
  logic [AW-1:0]    raddr [NS];
  logic [EB-1:0]    rdata [NS];
  logic [EB-1:0]    entry_w;

  logic                  load_go, eval_go, out_free;
  logic [LABEL_BITS-1:0] la, lb;
  logic [COUNT_BITS-1:0] ca, cb, cmin;
  logic [IW-1:0]         len_a, len_b;
  logic [TB-1:0]         tot_a, tot_b, big;
  logic [CMP_W-1:0]      big_w, ovl_w;
  logic [TB-1:0]         err;
  logic                  active;
  logic [SUM_W-1:0]      err_sum;
  logic                  lens_ok;

  assign entry_w  = cmd_data_i[EB-1:0];
  assign cmd_pop_o = (state_q == glmf_pkg::ST_IDLE) && cmd_valid_i;
  assign load_go  = cmd_pop_o && !cmd_i.is_eval;
  assign eval_go  = cmd_pop_o && cmd_i.is_eval;
  assign out_free = !res_valid_q || res_ready_i;

  // label stores
  assign raddr[glmf_pkg::STORE_FIRST_VERTEX]  = s_d[AW-1:0];
  assign raddr[glmf_pkg::STORE_FIRST_EDGE]    = s_d[AW-1:0];
  assign raddr[glmf_pkg::STORE_SECOND_VERTEX] = t_d[AW-1:0];
  assign raddr[glmf_pkg::STORE_SECOND_EDGE]   = t_d[AW-1:0];

  for (genvar k = 0; k < NS; k++) begin : g_store
    assign we[k] = load_go && (cmd_i.store_sel == glmf_pkg::STORE_SEL_BITS'(k))
                   && (len_q[k] < IW'(MAX_LABELS));
    glmf_ram #(
      .WIDTH (EB),
      .DEPTH (MAX_LABELS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we[k]),
      .waddr_i (len_q[k][AW-1:0]),
      .wdata_i (entry_w),
      .raddr_i (raddr[k]),
      .rdata_o (rdata[k])
    );
  end

  // merge step operands for the pair in work
  always_comb begin
    if (edge_phase_q) begin
      la    = rdata[glmf_pkg::STORE_FIRST_EDGE][LABEL_BITS-1:0];
      ca    = rdata[glmf_pkg::STORE_FIRST_EDGE][EB-1:LABEL_BITS];
      lb    = rdata[glmf_pkg::STORE_SECOND_EDGE][LABEL_BITS-1:0];
      cb    = rdata[glmf_pkg::STORE_SECOND_EDGE][EB-1:LABEL_BITS];
      len_a = len_q[glmf_pkg::STORE_FIRST_EDGE];
      len_b = len_q[glmf_pkg::STORE_SECOND_EDGE];
      tot_a = fe_q;
      tot_b = se_q;
    end else begin
      la    = rdata[glmf_pkg::STORE_FIRST_VERTEX][LABEL_BITS-1:0];
      ca    = rdata[glmf_pkg::STORE_FIRST_VERTEX][EB-1:LABEL_BITS];
      lb    = rdata[glmf_pkg::STORE_SECOND_VERTEX][LABEL_BITS-1:0];
      cb    = rdata[glmf_pkg::STORE_SECOND_VERTEX][EB-1:LABEL_BITS];
      len_a = len_q[glmf_pkg::STORE_FIRST_VERTEX];
      len_b = len_q[glmf_pkg::STORE_SECOND_VERTEX];
      tot_a = fv_q;
      tot_b = sv_q;
    end
    active = (s_q < len_a) && (t_q < len_b);
    cmin   = (ca <= cb) ? ca : cb;
    big    = (tot_a > tot_b) ? tot_a : tot_b;
    big_w  = CMP_W'(big);
    ovl_w  = CMP_W'(ovl_q);
    err    = (big_w > ovl_w) ? TB'(big_w - ovl_w) : '0;
  end

  assign err_sum = SUM_W'(verr_q) + SUM_W'(eerr_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      glmf_pkg::ST_IDLE: begin
        if (eval_go) begin
          state_d = glmf_pkg::ST_MERGE;
        end
      end
      glmf_pkg::ST_MERGE: begin
        if (!active) begin
          state_d = edge_phase_q ? glmf_pkg::ST_ECHECK : glmf_pkg::ST_VCHECK;
        end
      end
      glmf_pkg::ST_VCHECK: begin
        state_d = (verr_q > TB'(bound_i)) ? glmf_pkg::ST_RESULT : glmf_pkg::ST_MERGE;
      end
      glmf_pkg::ST_ECHECK: state_d = glmf_pkg::ST_RESULT;
      glmf_pkg::ST_RESULT: begin
        if (out_free) begin
          state_d = glmf_pkg::ST_IDLE;
        end
      end
      default: state_d = glmf_pkg::ST_IDLE;
    endcase
  end

  // datapath and store bookkeeping
  always_comb begin
    len_d        = len_q;
    drop_d       = drop_q;
    s_d          = s_q;
    t_d          = t_q;
    ovl_d        = ovl_q;
    edge_phase_d = edge_phase_q;
    verr_d       = verr_q;
    eerr_d       = eerr_q;
    early_d      = early_q;
    pass_d       = pass_q;
    res_valid_d  = res_valid_q && !res_ready_i;
    res_d        = res_q;
    case (state_q)
      glmf_pkg::ST_IDLE: begin
        s_d          = '0;
        t_d          = '0;
        ovl_d        = '0;
        edge_phase_d = 1'b0;
        if (load_go) begin
          for (int k = 0; k < NS; k++) begin
            if (cmd_i.store_sel == glmf_pkg::STORE_SEL_BITS'(k)) begin
              if (len_q[k] < IW'(MAX_LABELS)) begin
                len_d[k] = len_q[k] + IW'(1);
              end else begin
                drop_d = 1'b1;
              end
            end
          end
        end
      end
      glmf_pkg::ST_MERGE: begin
        if (active) begin
          if (la == lb) begin
            ovl_d = ovl_q + OVL_W'(cmin);
            s_d   = s_q + IW'(1);
            t_d   = t_q + IW'(1);
          end else if (la < lb) begin
            s_d = s_q + IW'(1);
          end else begin
            t_d = t_q + IW'(1);
          end
        end else if (edge_phase_q) begin
          eerr_d = err;
        end else begin
          verr_d = err;
        end
      end
      glmf_pkg::ST_VCHECK: begin
        if (verr_q > TB'(bound_i)) begin
          early_d = 1'b1;
          pass_d  = 1'b0;
          eerr_d  = '0;
        end else begin
          early_d      = 1'b0;
          edge_phase_d = 1'b1;
          s_d          = '0;
          t_d          = '0;
          ovl_d        = '0;
        end
      end
      glmf_pkg::ST_ECHECK: begin
        pass_d = (err_sum <= SUM_W'(bound_i));
      end
      glmf_pkg::ST_RESULT: begin
        if (out_free) begin
          res_valid_d              = 1'b1;
          res_d.pass               = pass_q;
          res_d.rejected_on_vertices = early_q;
          res_d.vertex_error       = verr_q;
          res_d.edge_error         = eerr_q;
          res_d.overflow           = drop_q;
          drop_d                   = 1'b0;
          for (int k = 0; k < NS; k++) begin
            len_d[k] = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= glmf_pkg::ST_IDLE;
      for (int k = 0; k < NS; k++) begin
        len_q[k] <= '0;
      end
      drop_q       <= 1'b0;
      s_q          <= '0;
      t_q          <= '0;
      ovl_q        <= '0;
      edge_phase_q <= 1'b0;
      early_q      <= 1'b0;
      pass_q       <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      len_q        <= len_d;
      drop_q       <= drop_d;
      s_q          <= s_d;
      t_q          <= t_d;
      ovl_q        <= ovl_d;
      edge_phase_q <= edge_phase_d;
      early_q      <= early_d;
      pass_q       <= pass_d;
      res_valid_q  <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    verr_q <= verr_d;
    eerr_q <= eerr_d;
    res_q  <= res_d;
    if (eval_go) begin
      fv_q <= cmd_data_i[EB+TB-1:EB];
      sv_q <= cmd_data_i[EB+2*TB-1:EB+TB];
      fe_q <= cmd_data_i[EB+3*TB-1:EB+2*TB];
      se_q <= cmd_data_i[EB+4*TB-1:EB+3*TB];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // fill counts stay within the store depth
  always_comb begin
    lens_ok = 1'b1;
    for (int k = 0; k < NS; k++) begin
      if (len_q[k] > IW'(MAX_LABELS)) begin
        lens_ok = 1'b0;
      end
    end
  end

  `GLMF_ASSERT(a_lens_in_range, lens_ok, "store fill count beyond depth")
  `GLMF_ASSERT(a_merge_idx, (state_q == glmf_pkg::ST_MERGE) |-> (s_q <= len_a && t_q <= len_b), "merge index past list end")
  `GLMF_ASSERT(a_early_result, (res_valid_q && res_q.rejected_on_vertices) |-> (!res_q.pass && res_q.edge_error == '0), "early reject with pass or edge error")
  `GLMF_NEVER(a_result_lost, res_valid_q && !res_ready_i && $past(res_valid_q && !res_ready_i) && !$stable(res_q), "held result changed")

endmodule

// ----- test/graph_label_multiset_filter_tb.sv -----
`timescale 1ns / 100ps

module graph_label_multiset_filter_tb;

  localparam int unsigned TOTAL_BITS     = glmf_pkg::TOTAL_BITS;
  localparam int unsigned NUM_TOTALS     = glmf_pkg::NUM_TOTALS;
  localparam int unsigned MODE_BITS      = glmf_pkg::MODE_BITS;
  localparam int unsigned BOUND_BITS     = glmf_pkg::BOUND_BITS;
  localparam int unsigned NUM_STORES     = glmf_pkg::NUM_STORES;
  localparam int unsigned STORE_SEL_BITS = glmf_pkg::STORE_SEL_BITS;
  localparam int unsigned OUT_DATA_BITS  = glmf_pkg::OUT_DATA_BITS;
  localparam int unsigned OUT_TDATA_W    = glmf_pkg::OUT_TDATA_W;

  typedef glmf_pkg::res_t res_t;

  localparam int unsigned DEPTH        = glmf_pkg::MAX_LABELS_DEF;
  localparam int unsigned LBITS        = glmf_pkg::LABEL_BITS_DEF;
  localparam int unsigned CBITS        = glmf_pkg::COUNT_BITS_DEF;
  localparam int unsigned IN_FIELD_W   = LBITS + CBITS + NUM_TOTALS * TOTAL_BITS;
  localparam int unsigned IN_TDATA_W   = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int unsigned TOTAL_MAX    = (1 << TOTAL_BITS) - 1;
  // longest evaluate plus what the command queue may still hold
  localparam int unsigned SETTLE_CYCLES = 400;
  localparam int unsigned RANDOM_ITEMS  = 1050;

  // mode codes the block ignores
  localparam logic [MODE_BITS-1:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [MODE_BITS-1:0] MODE_SPARE_MID   = 3'd6;
  localparam logic [MODE_BITS-1:0] MODE_SPARE_LAST  = 3'd7;

  typedef enum logic {ROW_ITEM, ROW_BOUND} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [MODE_BITS-1:0]    mode;
    logic [LBITS-1:0]        label;
    logic [CBITS-1:0]        count;
    logic [TOTAL_BITS-1:0]   fv;
    logic [TOTAL_BITS-1:0]   sv;
    logic [TOTAL_BITS-1:0]   fe;
    logic [TOTAL_BITS-1:0]   se;
    logic [BOUND_BITS-1:0]   bound;
    logic                    typed;
    res_t                    verdict;
  } stim_row_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  // label, count, first_vertex_count, second_vertex_count,
  // first_edge_count, second_edge_count
  logic [IN_TDATA_W-1:0]        s_axis_tdata;
  // mode
  logic [MODE_BITS-1:0]         s_axis_tuser;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  // pass, rejected_on_vertices, vertex_error, edge_error, overflow
  logic [OUT_TDATA_W-1:0]       m_axis_tdata;
  logic                         cfg_we_i;
  logic [BOUND_BITS-1:0]        cfg_wdata_i;

  // mirror of the label stores and filter settings
  logic [LBITS-1:0]      label_mirror [NUM_STORES*DEPTH];
  logic [CBITS-1:0]      count_mirror [NUM_STORES*DEPTH];
  int                    fill_mirror  [NUM_STORES];
  bit                    dropped_mirror;
  logic [BOUND_BITS-1:0] bound_mirror;

  res_t      verdicts_due [$];
  stim_row_t directed_rows [$];

  int tx_idle_pct;
  int rx_idle_pct;
  int errors;
  int items_sent;
  int loads_sent;
  int evals_sent;
  int spare_sent;
  int bound_writes;
  int pass_seen;
  int reject_seen;
  int overflow_seen;

  graph_label_multiset_filter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // overall time limit
  initial begin
    #2000000;
    $display("graph_label_multiset_filter test failed");
    $finish;
  end

  // sum of the smaller counts over labels shared by two stores
  function automatic longint unsigned label_overlap(input int a, input int b);
    int s;
    int t;
    longint unsigned sum;
    logic [LBITS-1:0] la;
    logic [LBITS-1:0] lb;
    logic [CBITS-1:0] ca;
    logic [CBITS-1:0] cb;
    s = 0;
    t = 0;
    sum = 0;
    while (s < fill_mirror[a] && t < fill_mirror[b]) begin
      la = label_mirror[a*DEPTH + s];
      lb = label_mirror[b*DEPTH + t];
      if (la == lb) begin
        ca = count_mirror[a*DEPTH + s];
        cb = count_mirror[b*DEPTH + t];
        sum += (ca <= cb) ? ca : cb;
        s++;
        t++;
      end else if (la < lb) begin
        s++;
      end else begin
        t++;
      end
    end
    return sum;
  endfunction

  // larger total minus overlap, clamped at zero
  function automatic longint unsigned edit_gap(input longint unsigned ta,
                                               input longint unsigned tb,
                                               input longint unsigned ov);
    longint unsigned big;
    big = (ta > tb) ? ta : tb;
    return (big > ov) ? big - ov : 0;
  endfunction

  // follow one accepted transfer through the filter
  task automatic mirror_item(input logic [MODE_BITS-1:0] mode, input logic [LBITS-1:0] label,
                             input logic [CBITS-1:0] count,
                             input logic [TOTAL_BITS-1:0] fv, input logic [TOTAL_BITS-1:0] sv,
                             input logic [TOTAL_BITS-1:0] fe, input logic [TOTAL_BITS-1:0] se,
                             output bit produced, output res_t verdict);
    int k;
    longint unsigned verr;
    longint unsigned eerr;
    produced = 1'b0;
    verdict  = '0;
    if (mode <= glmf_pkg::MODE_LOAD_SE) begin
      k = int'(mode[STORE_SEL_BITS-1:0]);
      if (fill_mirror[k] >= DEPTH) begin
        dropped_mirror = 1'b1;
      end else begin
        label_mirror[k*DEPTH + fill_mirror[k]] = label;
        count_mirror[k*DEPTH + fill_mirror[k]] = count;
        fill_mirror[k]++;
      end
    end else if (mode == glmf_pkg::MODE_EVAL) begin
      verr = edit_gap(fv, sv, label_overlap(int'(glmf_pkg::STORE_FIRST_VERTEX),
                                            int'(glmf_pkg::STORE_SECOND_VERTEX)));
      eerr = 0;
      if (verr > bound_mirror) begin
        verdict.rejected_on_vertices = 1'b1;
      end else begin
        eerr = edit_gap(fe, se, label_overlap(int'(glmf_pkg::STORE_FIRST_EDGE),
                                              int'(glmf_pkg::STORE_SECOND_EDGE)));
        verdict.pass = (verr + eerr <= bound_mirror);
      end
      verdict.vertex_error = verr[TOTAL_BITS-1:0];
      verdict.edge_error   = eerr[TOTAL_BITS-1:0];
      verdict.overflow     = dropped_mirror;
      for (int i = 0; i < NUM_STORES; i++) fill_mirror[i] = 0;
      dropped_mirror = 1'b0;
      produced = 1'b1;
    end
  endtask

  // one input transfer, then a random gap
  task automatic send_item(input logic [MODE_BITS-1:0] mode, input logic [LBITS-1:0] label,
                           input logic [CBITS-1:0] count,
                           input logic [TOTAL_BITS-1:0] fv, input logic [TOTAL_BITS-1:0] sv,
                           input logic [TOTAL_BITS-1:0] fe, input logic [TOTAL_BITS-1:0] se,
                           input bit use_model, input res_t typed);
    logic [IN_TDATA_W-1:0] word;
    bit produced;
    res_t verdict;
    word = '0;
    word[IN_FIELD_W-1:0] = {se, fe, sv, fv, count, label};
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    mirror_item(mode, label, count, fv, sv, fe, se, produced, verdict);
    if (produced) verdicts_due.insert(verdicts_due.size(), use_model ? verdict : typed);
    if (mode <= glmf_pkg::MODE_LOAD_SE) loads_sent++;
    else if (mode == glmf_pkg::MODE_EVAL) evals_sent++;
    else spare_sent++;
    if (mode <= glmf_pkg::MODE_EVAL) items_sent++;
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk_i);
    end
  endtask

  // hold the sender until every verdict is in and the back end has gone quiet
  task automatic drain_verdicts();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_bound(input logic [BOUND_BITS-1:0] v);
    drain_verdicts();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    bound_mirror = v;
    bound_writes++;
  endtask

  // totals near the overlap so that passes and near misses both turn up
  function automatic void pick_totals(input longint unsigned ov,
                                      output logic [TOTAL_BITS-1:0] ta,
                                      output logic [TOTAL_BITS-1:0] tb);
    longint unsigned big;
    logic [TOTAL_BITS-1:0] other;
    case ($urandom_range(3))
      0:       big = ov;
      1, 2:    big = ov + $urandom_range(0, bound_mirror + 3);
      default: big = $urandom_range(0, TOTAL_MAX);
    endcase
    if (big > TOTAL_MAX) big = TOTAL_MAX;
    other = TOTAL_BITS'($urandom_range(0, int'(big)));
    if ($urandom_range(1)) begin
      ta = big[TOTAL_BITS-1:0];
      tb = other;
    end else begin
      ta = other;
      tb = big[TOTAL_BITS-1:0];
    end
  endfunction

  task automatic send_spare();
    send_item(MODE_BITS'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)),
              LBITS'($urandom), CBITS'($urandom),
              TOTAL_BITS'($urandom), TOTAL_BITS'($urandom),
              TOTAL_BITS'($urandom), TOTAL_BITS'($urandom), 1'b1, '0);
  endtask

  // fill the four stores with a graph pair and evaluate it
  task automatic send_random_graph(input bit force_full);
    int full_store;
    int len;
    logic [LBITS-1:0] base_v;
    logic [LBITS-1:0] base_e;
    logic [LBITS-1:0] lab;
    logic [CBITS-1:0] cnt;
    logic [MODE_BITS-1:0] mode;
    logic [TOTAL_BITS-1:0] fv, sv, fe, se;
    full_store = force_full ? 0 : (($urandom_range(11) == 0) ? $urandom_range(3) : -1);
    base_v = LBITS'($urandom);
    base_e = LBITS'($urandom);
    for (int k = 0; k < NUM_STORES; k++) begin
      mode = MODE_BITS'(glmf_pkg::MODE_LOAD_FV) + MODE_BITS'(k);
      if (k == full_store) len = $urandom_range(DEPTH + 1, DEPTH + 4);
      else if ($urandom_range(14) == 0) len = $urandom_range(7, DEPTH);
      else len = $urandom_range(0, 6);
      lab = (k < 2) ? base_v : base_e;
      for (int i = 0; i < len; i++) begin
        lab = lab + LBITS'($urandom_range(1, 2));
        // now and then a label out of order
        if ($urandom_range(19) == 0) lab = LBITS'($urandom);
        cnt = $urandom_range(1) ? CBITS'($urandom_range(1, 20)) : CBITS'($urandom);
        send_item(mode, lab, cnt, TOTAL_BITS'($urandom), TOTAL_BITS'($urandom),
                  TOTAL_BITS'($urandom), TOTAL_BITS'($urandom), 1'b1, '0);
        if ($urandom_range(39) == 0) send_spare();
      end
    end
    pick_totals(label_overlap(int'(glmf_pkg::STORE_FIRST_VERTEX),
                              int'(glmf_pkg::STORE_SECOND_VERTEX)), fv, sv);
    pick_totals(label_overlap(int'(glmf_pkg::STORE_FIRST_EDGE),
                              int'(glmf_pkg::STORE_SECOND_EDGE)), fe, se);
    send_item(glmf_pkg::MODE_EVAL, LBITS'($urandom), CBITS'($urandom), fv, sv, fe, se,
              1'b1, '0);
  endtask

  // table rows
  function automatic stim_row_t item_row(input logic [MODE_BITS-1:0] mode,
                                         input logic [LBITS-1:0] label,
                                         input logic [CBITS-1:0] count,
                                         input logic [TOTAL_BITS-1:0] fv,
                                         input logic [TOTAL_BITS-1:0] sv,
                                         input logic [TOTAL_BITS-1:0] fe,
                                         input logic [TOTAL_BITS-1:0] se);
    stim_row_t r;
    r = '0;
    r.kind  = ROW_ITEM;
    r.mode  = mode;
    r.label = label;
    r.count = count;
    r.fv    = fv;
    r.sv    = sv;
    r.fe    = fe;
    r.se    = se;
    return r;
  endfunction

  function automatic stim_row_t bound_row(input logic [BOUND_BITS-1:0] v);
    stim_row_t r;
    r = '0;
    r.kind  = ROW_BOUND;
    r.bound = v;
    return r;
  endfunction

  function automatic stim_row_t checked_row(input logic [TOTAL_BITS-1:0] fv,
                                            input logic [TOTAL_BITS-1:0] sv,
                                            input logic [TOTAL_BITS-1:0] fe,
                                            input logic [TOTAL_BITS-1:0] se,
                                            input logic ok, input logic early,
                                            input logic [TOTAL_BITS-1:0] verr,
                                            input logic [TOTAL_BITS-1:0] eerr,
                                            input logic dropped);
    stim_row_t r;
    r = item_row(glmf_pkg::MODE_EVAL, '0, '0, fv, sv, fe, se);
    r.typed                        = 1'b1;
    r.verdict.pass                 = ok;
    r.verdict.rejected_on_vertices = early;
    r.verdict.vertex_error         = verr;
    r.verdict.edge_error           = eerr;
    r.verdict.overflow             = dropped;
    return r;
  endfunction

  // append one row to the directed table
  function automatic void add_row(input stim_row_t r);
    directed_rows.insert(directed_rows.size(), r);
  endfunction

  task automatic check_field(input string fname, input logic [TOTAL_BITS-1:0] want,
                             input logic [TOTAL_BITS-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      errors++;
    end
  endtask

  // receiver: random back-pressure and checking of every result transfer
  always @(posedge clk_i) begin : watch_results
    res_t got;
    res_t want;
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = res_t'(m_axis_tdata[OUT_DATA_BITS-1:0]);
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = verdicts_due.pop_front();
        check_field("pass", want.pass, got.pass);
        check_field("rejected_on_vertices", want.rejected_on_vertices,
                    got.rejected_on_vertices);
        check_field("vertex_error", want.vertex_error, got.vertex_error);
        check_field("edge_error", want.edge_error, got.edge_error);
        check_field("overflow", want.overflow, got.overflow);
        if (want.pass) pass_seen++;
        if (want.rejected_on_vertices) reject_seen++;
        if (want.overflow) overflow_seen++;
      end
    end
  end

  initial begin
    logic [BOUND_BITS-1:0] bound_plan [6];
    int target;
    bit half_done;
    bit first_graph;
    stim_row_t r;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    for (int i = 0; i < NUM_STORES; i++) fill_mirror[i] = 0;
    dropped_mirror = 1'b0;
    bound_mirror   = glmf_pkg::BOUND_RESET;
    errors = 0;
    items_sent = 0;
    loads_sent = 0;
    evals_sent = 0;
    spare_sent = 0;
    bound_writes = 0;
    pass_seen = 0;
    reject_seen = 0;
    overflow_seen = 0;
    tx_idle_pct = 25;
    rx_idle_pct = 68;

    // directed table: empty stores, extremes, ignored modes, early reject,
    // overlap above the total, unsorted lists, bound at both ends
    add_row(checked_row(0, 0, 0, 0, 1'b1, 1'b0, 0, 0, 1'b0));
    add_row(checked_row(TOTAL_BITS'(TOTAL_MAX), 0, 0, 0, 1'b0, 1'b1,
                        TOTAL_BITS'(TOTAL_MAX), 0, 1'b0));
    add_row(item_row(glmf_pkg::MODE_LOAD_FV, 0, CBITS'(TOTAL_MAX), 0, 0, 0, 0));
    add_row(item_row(glmf_pkg::MODE_LOAD_SV, 0, CBITS'(TOTAL_MAX), 0, 0, 0, 0));
    add_row(item_row(glmf_pkg::MODE_LOAD_FE, '1, 1, 0, 0, 0, 0));
    add_row(item_row(glmf_pkg::MODE_LOAD_SE, '1, CBITS'(TOTAL_MAX), 0, 0, 0, 0));
    add_row(item_row(glmf_pkg::MODE_EVAL, 0, 0, TOTAL_BITS'(TOTAL_MAX),
                     TOTAL_BITS'(TOTAL_MAX), 1, 0));
    add_row(item_row(MODE_SPARE_FIRST, '1, '1, '1, '1, '1, '1));
    add_row(item_row(MODE_SPARE_MID, '1, '1, '1, '1, '1, '1));
    add_row(item_row(MODE_SPARE_LAST, '1, '1, '1, '1, '1, '1));
    add_row(bound_row(0));
    add_row(item_row(glmf_pkg::MODE_LOAD_FV, 10, 3, 0, 0, 0, 0));
    add_row(item_row(glmf_pkg::MODE_LOAD_SV, 10, 5, 0, 0, 0, 0));
    add_row(item_row(glmf_pkg::MODE_LOAD_SV, 20, 2, 0, 0, 0, 0));
    add_row(item_row(glmf_pkg::MODE_EVAL, 0, 0, 3, 4, 0, 0));
    add_row(item_row(glmf_pkg::MODE_LOAD_FE, 7, 4000, 0, 0, 0, 0));
    add_row(item_row(glmf_pkg::MODE_LOAD_SE, 7, 4000, 0, 0, 0, 0));
    add_row(item_row(glmf_pkg::MODE_EVAL, 0, 0, 0, 0, 5, 5));
    add_row(item_row(glmf_pkg::MODE_LOAD_FV, 30, 1, 0, 0, 0, 0));
    add_row(item_row(glmf_pkg::MODE_LOAD_FV, 5, 1, 0, 0, 0, 0));
    add_row(item_row(glmf_pkg::MODE_LOAD_SV, 5, 2, 0, 0, 0, 0));
    add_row(item_row(glmf_pkg::MODE_LOAD_SV, 30, 2, 0, 0, 0, 0));
    add_row(item_row(glmf_pkg::MODE_EVAL, 0, 0, 1, 2, 0, 0));
    add_row(bound_row('1));
    add_row(checked_row(255, 0, 1, 0, 1'b0, 1'b0, 255, 1, 1'b0));

    // reset
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      if (r.kind == ROW_BOUND) set_bound(r.bound);
      else send_item(r.mode, r.label, r.count, r.fv, r.sv, r.fe, r.se, !r.typed, r.verdict);
    end

    // random graph pairs in three idling phases, two bounds per phase
    bound_plan[0] = 12;
    bound_plan[1] = 0;
    bound_plan[2] = '1;
    bound_plan[3] = BOUND_BITS'($urandom);
    bound_plan[4] = BOUND_BITS'($urandom_range(1, 30));
    bound_plan[5] = 1;
    first_graph = 1'b1;
    for (int p = 0; p < 3; p++) begin
      case (p)
        0:       begin tx_idle_pct = 25; rx_idle_pct = 68; end
        1:       begin tx_idle_pct = 68; rx_idle_pct = 25; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      set_bound(bound_plan[2*p]);
      target = items_sent + RANDOM_ITEMS / 3;
      half_done = 1'b0;
      while (items_sent < target) begin
        if (!half_done && items_sent >= target - RANDOM_ITEMS / 6) begin
          set_bound(bound_plan[2*p + 1]);
          half_done = 1'b1;
        end
        // the first pair overfills a store on purpose
        send_random_graph(first_graph);
        first_graph = 1'b0;
      end
    end

    drain_verdicts();
    $display("sent %0d loads, %0d evaluates, %0d ignored transfers; %0d bound writes",
             loads_sent, evals_sent, spare_sent, bound_writes);
    $display("results: %0d passed, %0d rejected on vertices, %0d with overflow",
             pass_seen, reject_seen, overflow_seen);
    if (errors == 0) begin
      $display("graph_label_multiset_filter test passed");
    end else begin
      $display("graph_label_multiset_filter test failed");
    end
    $finish;
  end

endmodule

// ----- graph_label_multiset_filter.f -----
+incdir+rtl
rtl/glmf_pkg.sv
rtl/glmf_ram.sv
rtl/glmf_queue.sv
rtl/glmf_front.sv
rtl/glmf_back.sv
rtl/graph_label_multiset_filter.sv
test/graph_label_multiset_filter_tb.sv
